@@ hdl/lock_manager_fifo_waiters_macros.svh @@
// assertion macros for the lock manager checker
`ifndef LOCK_MANAGER_FIFO_WAITERS_MACROS_SVH
`define LOCK_MANAGER_FIFO_WAITERS_MACROS_SVH

// clocked check, switched off while reset is low
`define LMFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define LMFW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/lmfw_pkg.sv @@
// shared types, constants and helpers of the lock manager
`default_nettype none
package lmfw_pkg;

  localparam int NUM_CLIENTS = 4;
  localparam int NUM_LOCKS   = 2;
  localparam int NUM_BUCKETS = 60;

  localparam int HEAD_W = (NUM_CLIENTS > 2) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CNT_W  = $clog2(NUM_CLIENTS + 1);
  localparam int SLOT_W = CNT_W + 1;
  localparam int OWN_W  = $clog2(NUM_CLIENTS + 1);
  localparam int LID_W  = $clog2(NUM_LOCKS + 1);
  localparam int LA_W   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int BA_W   = $clog2(NUM_BUCKETS);
  localparam int WIN_W  = 32 + $clog2(NUM_BUCKETS);

  localparam int DIV_N  = 48;
  localparam int DIV_D  = 32;
  localparam int DIV_CW = $clog2(DIV_N);

  // bucket index reduction: 12-bit digits of the epoch, residue by reciprocal
  localparam int MX_W   = BA_W + 12;
  localparam int MOD_K  = 26;
  localparam int PROD_W = MX_W + MOD_K;
  localparam logic [MOD_K-1:0] MOD_RECIP =
    MOD_K'(((64'd1 << MOD_K) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  localparam int CFG_AW = 3;
  localparam logic [31:0]      BT_RESET  = 32'd1000;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000 * NUM_BUCKETS);

  typedef enum logic [0:0] {
    REG_BUCKET_TICKS = 1'b0
  } lmfw_reg_t;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_RSVD    = 2'd3
  } lmfw_cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED       = 3'd0,
    ST_QUEUED        = 3'd1,
    ST_REFUSED       = 3'd2,
    ST_RELEASED      = 3'd3,
    ST_REL_REFUSED   = 3'd4,
    ST_QUERY_OK      = 3'd5,
    ST_QUERY_INVALID = 3'd6
  } lmfw_status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  client;
    logic [1:0]  lock_id;
    logic [47:0] now;
  } lmfw_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        handoff_valid;
    logic [1:0]  handoff_client;
    logic [2:0]  owner_code;
    logic [47:0] held_ticks;
    logic [2:0]  waiter_count;
    logic [31:0] grant_count;
    logic [47:0] total_held;
    logic [47:0] longest_hold;
    logic [47:0] window_usage;
  } lmfw_out_t;

  // per-lock record held in the lock memory
  typedef struct packed {
    logic [OWN_W-1:0]                  owner;
    logic [HEAD_W-1:0]                 head;
    logic [CNT_W-1:0]                  count;
    logic [47:0]                       grant_time;
    logic [47:0]                       hold_sum;
    logic [31:0]                       grants;
    logic [47:0]                       hold_max;
    logic [NUM_CLIENTS-1:0][1:0]       ring;
  } lmfw_lock_t;

  // one bucket row: epoch tag plus the usage of every lock
  typedef struct packed {
    logic [47:0]                 tag;
    logic [NUM_LOCKS-1:0][31:0]  usage;
  } lmfw_bkt_t;

  localparam int LOCK_W = $bits(lmfw_lock_t);
  localparam int BKT_W  = $bits(lmfw_bkt_t);

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } lmfw_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quotient;
    logic [DIV_D-1:0] remainder;
  } lmfw_div_rsp_t;

  function automatic logic [47:0] sat48(input logic [48:0] v);
    sat48 = v[48] ? '1 : v[47:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == '1) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

@@ hdl/lmfw_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module lmfw_div import lmfw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  lmfw_div_req_t req,
  output lmfw_div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_N-1:0]  quo_r, quo_nxt;
  logic [DIV_D-1:0]  rem_r, rem_nxt;
  logic [DIV_D-1:0]  dvs_r, dvs_nxt;
  logic [DIV_D:0]    trial;
  logic [DIV_D:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_N-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
      quo_nxt = {quo_r[DIV_N-2:0], ge};
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

@@ hdl/lmfw_ram.sv @@
// simple dual-port ram, registered read
`default_nettype none
module lmfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/lock_manager_fifo_waiters.sv @@
// top level of the lock manager with fifo wait queues
//
// Lock unit for NUM_LOCKS resources shared by NUM_CLIENTS client slots. One
// transaction is handled at a time: acquire, a refused release and a bad
// command pass from S_EXEC straight to S_DONE. A valid release that
// accounts hold time costs one 48-step pass of the shared divider (bucket
// epoch), a four-step reduction of that epoch to a bucket index, plus a
// read and a write per usage bucket touched, at most NUM_BUCKETS+1 buckets.
// A query costs one divider pass plus a read of each of the NUM_BUCKETS rows
// of the bucket memory. The bucket memory has one read and one write port; it
// has a valid flag per row, so no clearing pass runs after reset. A result
// waits in the output register while the next transaction is already accepted.
// bucket_ticks is written through the apb port at byte address 0; the user must
// write it only while the block is idle, which the block itself does not
// enforce. 0 is taken as 1.
`default_nettype none
module lock_manager_fifo_waiters import lmfw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lmfw_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lmfw_out_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_EP_GO,
    S_EP_WAIT,
    S_BK_GO,
    S_BK_WAIT,
    S_BRD,
    S_BWR,
    S_REL,
    S_Q_GO,
    S_Q_WAIT,
    S_QRD,
    S_QACC,
    S_QFIN,
    S_DONE
  } state_t;

  // control state and working registers
  state_t    state_r, state_nxt;
  lmfw_in_t  req_r, req_nxt;
  lmfw_lock_t rec_r, rec_nxt;
  lmfw_out_t res_r, res_nxt;
  lmfw_out_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [47:0] start_r, start_nxt;
  logic [47:0] epoch_r, epoch_nxt;
  logic [47:0] cur_r, cur_nxt;
  logic [48:0] bnd_r, bnd_nxt;
  logic [48:0] sum_r, sum_nxt;
  logic [BA_W-1:0] bidx_r, bidx_nxt;
  logic [BA_W-1:0] scan_r, scan_nxt;
  logic [1:0]      dig_r, dig_nxt;
  logic [NUM_CLIENTS-1:0][LID_W-1:0] owns_r, owns_nxt;
  logic [NUM_CLIENTS-1:0][LID_W-1:0] waits_r, waits_nxt;
  logic [NUM_LOCKS-1:0]   lk_vld_r, lk_vld_nxt;
  logic [NUM_BUCKETS-1:0] bk_vld_r, bk_vld_nxt;
  logic lk_rvld_r, lk_rvld_nxt;
  logic bk_rvld_r, bk_rvld_nxt;

  // configuration
  logic [31:0]      bt_r;
  logic [WIN_W-1:0] win_r;
  logic [31:0]      span;
  logic [31:0]      wr_span;
  logic             cfg_wr;

  // memory ports
  logic              lk_we, lk_re;
  logic [LA_W-1:0]   lk_raddr;
  lmfw_lock_t        lk_wdata;
  logic [LOCK_W-1:0] lk_rdata;
  logic              bk_we, bk_re;
  logic [BA_W-1:0]   bk_waddr, bk_raddr;
  lmfw_bkt_t         bk_wdata;
  logic [BKT_W-1:0]  bk_rdata;

  lmfw_div_req_t div_req;
  lmfw_div_rsp_t div_rsp;

  // decoded request
  logic             vid, cok, in_vid;
  logic [LA_W-1:0]  li, in_li;
  logic [HEAD_W-1:0] ci;
  logic [OWN_W-1:0] own_code_c;
  logic [LID_W-1:0] lid_code;
  logic [47:0]      now;
  logic [47:0]      win48;
  lmfw_lock_t       lk;
  lmfw_bkt_t        row;
  logic [47:0]      hold;
  logic [SLOT_W-1:0] slot_sum;
  logic [HEAD_W-1:0] slot;

  // epoch to bucket index, one 12-bit digit per cycle
  logic [3:0][11:0]  ep_dig;
  logic [MX_W-1:0]   mx;
  logic [PROD_W-1:0] mprod;
  logic [MX_W-1:0]   mq;
  logic [MX_W-1:0]   mrem;

  // scratch values of the next-state logic
  lmfw_lock_t       nrec;
  lmfw_bkt_t        nrow;
  logic [47:0]      live;
  logic [47:0]      tag1;
  logic [47:0]      seg_end;
  logic [47:0]      seg;
  logic [32:0]      usum;
  logic [1:0]       wcli;
  logic [HEAD_W-1:0] wi;
  logic [47:0]      ep;
  logic [48:0]      ws;
  logic [47:0]      wst;

  assign span    = (bt_r == '0) ? 32'd1 : bt_r;
  assign wr_span = (cfg_pwdata == '0) ? 32'd1 : cfg_pwdata;
  assign win48   = 48'(win_r);
  assign now     = req_r.now;

  assign in_vid = (in_data.lock_id != 2'd0) && (int'(in_data.lock_id) <= NUM_LOCKS);
  assign in_li  = in_vid ? LA_W'(in_data.lock_id - 2'd1) : '0;
  assign vid    = (req_r.lock_id != 2'd0) && (int'(req_r.lock_id) <= NUM_LOCKS);
  assign cok    = int'(req_r.client) < NUM_CLIENTS;
  assign li     = vid ? LA_W'(req_r.lock_id - 2'd1) : '0;
  assign ci     = HEAD_W'(req_r.client);
  assign own_code_c = OWN_W'(req_r.client) + OWN_W'(1);
  assign lid_code   = LID_W'(req_r.lock_id);

  // entries never written read as their reset value
  assign lk   = lk_rvld_r ? lmfw_lock_t'(lk_rdata) : '0;
  assign row  = bk_rvld_r ? lmfw_bkt_t'(bk_rdata) : '0;
  assign hold = now - lk.grant_time;

  // tail slot of the wait ring
  assign slot_sum = SLOT_W'(lk.head) + SLOT_W'(lk.count);
  assign slot     = (int'(slot_sum) >= NUM_CLIENTS) ?
                    HEAD_W'(slot_sum - SLOT_W'(NUM_CLIENTS)) : HEAD_W'(slot_sum);

  // residue step: (r * 4096 + digit) mod NUM_BUCKETS, most significant first
  assign ep_dig = epoch_r;
  assign mx     = {bidx_r, ep_dig[~dig_r]};
  assign mprod  = PROD_W'(mx) * PROD_W'(MOD_RECIP);
  assign mq     = MX_W'(mprod >> MOD_K);
  assign mrem   = mx - MX_W'(mq * MX_W'(NUM_BUCKETS));

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rec_nxt       = rec_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    start_nxt     = start_r;
    epoch_nxt     = epoch_r;
    cur_nxt       = cur_r;
    bnd_nxt       = bnd_r;
    sum_nxt       = sum_r;
    bidx_nxt      = bidx_r;
    scan_nxt      = scan_r;
    dig_nxt       = dig_r;
    owns_nxt      = owns_r;
    waits_nxt     = waits_r;
    lk_vld_nxt    = lk_vld_r;
    bk_vld_nxt    = bk_vld_r;
    lk_rvld_nxt   = lk_rvld_r;
    bk_rvld_nxt   = bk_rvld_r;

    lk_we    = 1'b0;
    lk_re    = 1'b0;
    lk_raddr = in_li;
    bk_we    = 1'b0;
    bk_re    = 1'b0;
    bk_waddr = bidx_r;
    bk_raddr = bidx_r;
    div_req  = '0;

    nrec    = lk;
    nrow    = row;
    live    = '0;
    tag1    = epoch_r + 48'd1;
    seg_end = now;
    seg     = '0;
    usum    = '0;
    wcli    = '0;
    wi      = '0;
    ep      = '0;
    ws      = sum_r;
    wst     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          lk_re       = 1'b1;
          lk_rvld_nxt = lk_vld_r[in_li];
          res_nxt     = '0;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        rec_nxt   = lk;
        state_nxt = S_DONE;
        case (req_r.command)
          CMD_ACQUIRE: begin
            if (!vid || !cok || owns_r[ci] != '0 || waits_r[ci] != '0) begin
              res_nxt.status = ST_REFUSED;
            end else if (lk.owner == '0) begin
              nrec.owner      = own_code_c;
              nrec.grant_time = now;
              nrec.grants     = sat_inc32(lk.grants);
              lk_we           = 1'b1;
              lk_vld_nxt[li]  = 1'b1;
              owns_nxt[ci]    = lid_code;
              res_nxt.status  = ST_GRANTED;
            end else if (int'(lk.count) >= NUM_CLIENTS) begin
              res_nxt.status = ST_REFUSED;
            end else begin
              nrec.ring[slot] = req_r.client;
              nrec.count      = lk.count + CNT_W'(1);
              lk_we           = 1'b1;
              lk_vld_nxt[li]  = 1'b1;
              waits_nxt[ci]   = lid_code;
              res_nxt.status  = ST_QUEUED;
            end
          end
          CMD_RELEASE: begin
            if (!vid || !cok || owns_r[ci] != lid_code || lk.owner != own_code_c) begin
              res_nxt.status = ST_REL_REFUSED;
            end else if (now >= lk.grant_time) begin
              rec_nxt.hold_sum = sat48({1'b0, lk.hold_sum} + {1'b0, hold});
              if (hold > lk.hold_max) begin
                rec_nxt.hold_max = hold;
              end
              // only the last window of the hold lands in buckets
              start_nxt = (hold > win48) ? now - win48 : lk.grant_time;
              state_nxt = S_EP_GO;
            end else begin
              // time went backwards: free without accounting
              state_nxt = S_REL;
            end
          end
          CMD_QUERY: begin
            if (vid) begin
              if (lk.owner != '0 && now >= lk.grant_time) begin
                live = hold;
              end
              res_nxt.status       = ST_QUERY_OK;
              res_nxt.owner_code   = 3'(lk.owner);
              res_nxt.held_ticks   = live;
              res_nxt.waiter_count = 3'(lk.count);
              res_nxt.grant_count  = lk.grants;
              res_nxt.total_held   = sat48({1'b0, lk.hold_sum} + {1'b0, live});
              res_nxt.longest_hold = (lk.hold_max > live) ? lk.hold_max : live;
              state_nxt            = S_Q_GO;
            end else begin
              res_nxt.status = ST_QUERY_INVALID;
            end
          end
          default: begin
            res_nxt.status = ST_QUERY_INVALID;
          end
        endcase
      end

      // epoch of the first accounted tick
      S_EP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = start_r;
        div_req.divisor  = span;
        state_nxt        = S_EP_WAIT;
      end

      S_EP_WAIT: begin
        if (div_rsp.done) begin
          epoch_nxt = div_rsp.quotient;
          bnd_nxt   = {1'b0, start_r} - 49'(div_rsp.remainder) + 49'(span);
          state_nxt = S_BK_GO;
        end
      end

      // bucket index of that epoch
      S_BK_GO: begin
        bidx_nxt  = '0;
        dig_nxt   = '0;
        state_nxt = S_BK_WAIT;
      end

      S_BK_WAIT: begin
        bidx_nxt = BA_W'(mrem);
        dig_nxt  = dig_r + 2'd1;
        if (dig_r == 2'd3) begin
          state_nxt = S_BRD;
        end
      end

      S_BRD: begin
        if (start_r < now) begin
          bk_re       = 1'b1;
          bk_raddr    = bidx_r;
          bk_rvld_nxt = bk_vld_r[bidx_r];
          state_nxt   = S_BWR;
        end else begin
          state_nxt = S_REL;
        end
      end

      // stale tag: row taken over for this epoch, all usages cleared
      S_BWR: begin
        if (row.tag != tag1) begin
          nrow.tag   = tag1;
          nrow.usage = '0;
        end
        seg_end = (bnd_r < {1'b0, now}) ? bnd_r[47:0] : now;
        seg     = seg_end - start_r;
        usum    = {1'b0, nrow.usage[li]} + 33'(seg);
        nrow.usage[li] = usum[32] ? '1 : usum[31:0];
        bk_we    = 1'b1;
        bk_waddr = bidx_r;
        bk_vld_nxt[bidx_r] = 1'b1;
        start_nxt = seg_end;
        epoch_nxt = epoch_r + 48'd1;
        bidx_nxt  = (bidx_r == BA_W'(NUM_BUCKETS - 1)) ? '0 : bidx_r + BA_W'(1);
        bnd_nxt   = bnd_r + 49'(span);
        state_nxt = S_BRD;
      end

      // free the lock and pass it to the oldest waiter
      S_REL: begin
        nrec           = rec_r;
        nrec.owner     = '0;
        owns_nxt[ci]   = '0;
        res_nxt.status = ST_RELEASED;
        if (rec_r.count != '0) begin
          wcli            = rec_r.ring[rec_r.head];
          wi              = HEAD_W'(wcli);
          nrec.head       = (rec_r.head == HEAD_W'(NUM_CLIENTS - 1)) ?
                            '0 : rec_r.head + HEAD_W'(1);
          nrec.count      = rec_r.count - CNT_W'(1);
          waits_nxt[wi]   = '0;
          nrec.owner      = OWN_W'(wcli) + OWN_W'(1);
          nrec.grant_time = now;
          nrec.grants     = sat_inc32(rec_r.grants);
          owns_nxt[wi]    = lid_code;
          res_nxt.handoff_valid  = 1'b1;
          res_nxt.handoff_client = wcli;
        end
        lk_we          = 1'b1;
        lk_vld_nxt[li] = 1'b1;
        state_nxt      = S_DONE;
      end

      // current epoch for the window scan
      S_Q_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = now;
        div_req.divisor  = span;
        state_nxt        = S_Q_WAIT;
      end

      S_Q_WAIT: begin
        if (div_rsp.done) begin
          cur_nxt   = div_rsp.quotient;
          sum_nxt   = '0;
          scan_nxt  = '0;
          state_nxt = S_QRD;
        end
      end

      S_QRD: begin
        bk_re       = 1'b1;
        bk_raddr    = scan_r;
        bk_rvld_nxt = bk_vld_r[scan_r];
        state_nxt   = S_QACC;
      end

      S_QACC: begin
        if (row.tag != '0) begin
          ep = row.tag - 48'd1;
          if (ep <= cur_r && (cur_r - ep) < 48'(NUM_BUCKETS)) begin
            sum_nxt = sum_r + 49'(row.usage[li]);
          end
        end
        if (scan_r == BA_W'(NUM_BUCKETS - 1)) begin
          state_nxt = S_QFIN;
        end else begin
          scan_nxt  = scan_r + BA_W'(1);
          state_nxt = S_QRD;
        end
      end

      // add the live hold, clipped to the window
      S_QFIN: begin
        if (rec_r.owner != '0 && now >= rec_r.grant_time) begin
          wst = rec_r.grant_time;
          if (now > win48 && wst < now - win48) begin
            wst = now - win48;
          end
          ws = sum_r + 49'(now - wst);
        end
        res_nxt.window_usage = sat48(ws);
        state_nxt            = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    lk_wdata = nrec;
    bk_wdata = nrow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      owns_r      <= '0;
      waits_r     <= '0;
      lk_vld_r    <= '0;
      bk_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      owns_r      <= owns_nxt;
      waits_r     <= waits_nxt;
      lk_vld_r    <= lk_vld_nxt;
      bk_vld_r    <= bk_vld_nxt;
    end
    req_r      <= req_nxt;
    rec_r      <= rec_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    start_r    <= start_nxt;
    epoch_r    <= epoch_nxt;
    cur_r      <= cur_nxt;
    bnd_r      <= bnd_nxt;
    sum_r      <= sum_nxt;
    bidx_r     <= bidx_nxt;
    scan_r     <= scan_nxt;
    dig_r      <= dig_nxt;
    lk_rvld_r  <= lk_rvld_nxt;
    bk_rvld_r  <= bk_rvld_nxt;
  end

  // apb register: window length kept precomputed
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_AW-1] == REG_BUCKET_TICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_r  <= BT_RESET;
      win_r <= WIN_RESET;
    end else if (cfg_wr) begin
      bt_r  <= cfg_pwdata;
      win_r <= WIN_W'(wr_span) * WIN_W'(NUM_BUCKETS);
    end
  end

  always_comb begin
    case (cfg_paddr[CFG_AW-1])
      REG_BUCKET_TICKS: cfg_prdata = bt_r;
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  lmfw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lmfw_ram #(
    .WIDTH (LOCK_W),
    .DEPTH (NUM_LOCKS)
  ) u_lock_mem (
    .clk   (clk),
    .we    (lk_we),
    .waddr (li),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  lmfw_ram #(
    .WIDTH (BKT_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_mem (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .re    (bk_re),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ hdl/lmfw_chk.sv @@
// port checker for the lock manager, bound to the top level
`default_nettype none
`include "lock_manager_fifo_waiters_macros.svh"
module lmfw_chk import lmfw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input lmfw_out_t out_data
);

  // reset leaves an empty output and a ready input
  `LMFW_ASSERT_RST(a_reset_clean, !rst_n |=> !out_valid && in_ready, "bad state after reset")

  // one transaction in flight: ready drops once an item is taken
  `LMFW_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken")

  // a waiting result holds
  `LMFW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed")

  // handoff only on a successful release
  `LMFW_ASSERT(a_handoff, out_valid && out_data.handoff_valid |-> out_data.status == ST_RELEASED, "handoff without release")

  // statistics only travel with a query answer
  `LMFW_ASSERT(a_stats_zero, out_valid && out_data.status != ST_QUERY_OK |-> out_data.grant_count == '0 && out_data.window_usage == '0, "stats outside query")

endmodule

bind lock_manager_fifo_waiters lmfw_chk u_lmfw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
